@@ rtl/core/slu_pkg.sv @@
// shared types, character codes and helpers for the string literal unescape block
package slu_pkg;

  localparam logic [7:0] CH_N         = 8'h6e;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;

  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_TAB = 8'd9;
  localparam logic [7:0] BYTE_NUL = 8'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    MODE_OPEN = 4'b0001,
    MODE_BODY = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       hex_digit_seen;
    logic [3:0] hex_partial;
    logic       open_error;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       well_formed;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
    dec_state_t state_next;
  } dec_out_t;

  localparam dec_state_t STATE_RESET = '{
    mode: MODE_OPEN, hex_digit_seen: 1'b0, hex_partial: 4'd0, open_error: 1'b0
  };

  // returns {valid, value}
  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end
    return res;
  endfunction

  function automatic result_t data_item(input logic [7:0] b);
    result_t r;
    r.out_byte    = b;
    r.is_data     = 1'b1;
    r.well_formed = 1'b0;
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic result_t status_item(input logic wf);
    result_t r;
    r.out_byte    = 8'd0;
    r.is_data     = 1'b0;
    r.well_formed = wf;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/core/slu_decode.sv @@
// next-state and result logic for one input byte
module slu_decode (
  input  slu_pkg::dec_state_t state,
  input  logic [7:0]          in_byte,
  input  logic                frame_end,
  output slu_pkg::dec_out_t   dec
);
  import slu_pkg::*;

  logic [4:0]  hv;
  result_t     body_res;
  logic        body_emit;
  logic [7:0]  esc_val;

  assign hv = hex_lookup(in_byte);

  always_comb begin
    body_emit = (in_byte != CH_BACKSLASH);
    body_res  = data_item(in_byte);
    case (in_byte)
      CH_N:    esc_val = BYTE_LF;
      CH_R:    esc_val = BYTE_CR;
      CH_T:    esc_val = BYTE_TAB;
      CH_ZERO: esc_val = BYTE_NUL;
      default: esc_val = in_byte;
    endcase
  end

  always_comb begin
    dec.num        = 2'd0;
    dec.r0         = data_item(8'd0);
    dec.r1         = data_item(8'd0);
    dec.state_next = state;
    if (state.mode == MODE_OPEN) begin
      if (frame_end) begin
        dec.num        = 2'd1;
        dec.r0         = status_item(1'b0);
        dec.state_next = STATE_RESET;
      end else begin
        dec.state_next.open_error = (in_byte != CH_QUOTE);
        dec.state_next.mode       = MODE_BODY;
      end
    end else if (frame_end) begin
      if (state.mode == MODE_ESC) begin
        dec.num = 2'd2;
        dec.r0  = data_item(CH_BACKSLASH);
        dec.r1  = status_item(!state.open_error && in_byte == CH_QUOTE);
      end else if (state.mode == MODE_HEX && state.hex_digit_seen) begin
        dec.num = 2'd2;
        dec.r0  = data_item({4'd0, state.hex_partial});
        dec.r1  = status_item(!state.open_error && in_byte == CH_QUOTE);
      end else begin
        dec.num = 2'd1;
        dec.r0  = status_item(!state.open_error && in_byte == CH_QUOTE);
      end
      dec.state_next = STATE_RESET;
    end else begin
      case (state.mode)
        MODE_BODY: begin
          if (body_emit) begin
            dec.num = 2'd1;
            dec.r0  = body_res;
          end else begin
            dec.state_next.mode = MODE_ESC;
          end
        end
        MODE_ESC: begin
          if (in_byte == CH_X) begin
            dec.state_next.mode           = MODE_HEX;
            dec.state_next.hex_digit_seen = 1'b0;
            dec.state_next.hex_partial    = 4'd0;
          end else begin
            dec.num             = 2'd1;
            dec.r0              = data_item(esc_val);
            dec.state_next.mode = MODE_BODY;
          end
        end
        MODE_HEX: begin
          if (hv[4]) begin
            if (!state.hex_digit_seen) begin
              dec.state_next.hex_partial    = hv[3:0];
              dec.state_next.hex_digit_seen = 1'b1;
            end else begin
              dec.num                       = 2'd1;
              dec.r0                        = data_item({state.hex_partial, hv[3:0]});
              dec.state_next.hex_digit_seen = 1'b0;
              dec.state_next.hex_partial    = 4'd0;
              dec.state_next.mode           = MODE_BODY;
            end
          end else begin
            dec.state_next.hex_digit_seen = 1'b0;
            dec.state_next.hex_partial    = 4'd0;
            dec.state_next.mode           = body_emit ? MODE_BODY : MODE_ESC;
            if (state.hex_digit_seen) begin
              dec.r0 = data_item({4'd0, state.hex_partial});
              if (body_emit) begin
                dec.num = 2'd2;
                dec.r1  = body_res;
              end else begin
                dec.num = 2'd1;
              end
            end else if (body_emit) begin
              dec.num = 2'd1;
              dec.r0  = body_res;
            end
          end
        end
        default: begin
          dec.state_next = STATE_RESET;
        end
      endcase
    end
    if (dec.num == 2'd1) begin
      dec.r0.run_last = 1'b1;
    end else if (dec.num == 2'd2) begin
      dec.r1.run_last = 1'b1;
    end
  end

endmodule

@@ rtl/core/string_literal_unescape_top.sv @@
// Decoder for one C-style quoted string literal per frame.
// Input channel: in_byte and frame_end with in_valid / in_stall. Bytes arrive
// in order, quotes included; frame_end marks the closing byte.
// Output channel: out_byte, is_data, well_formed, run_last with out_valid /
// out_stall. Each request yields zero, one or two results: decoded data
// bytes, and on the closing byte a status result (is_data 0) that reports
// whether the literal was well formed. run_last flags the final result of
// one request.
// A request is decoded in the cycle it is accepted, and its results are
// written into a four-entry result queue that drives the output port.
// Throughput: one request per cycle while requests make at most one result
// and the receiver does not stall; requests that make two results fill the
// queue faster than the output port drains it, one result per cycle while out_stall is low.
// in_stall rises while the queue holds more than two results, keeping room
// for two results; under out_stall the queue fills and in_stall holds input.
// Reset (rst, synchronous) empties the queue and returns the decoder to
// waiting for an opening quote.
module string_literal_unescape_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       well_formed,
  output logic       run_last
);
  import slu_pkg::*;

  dec_state_t           state;
  dec_out_t             dec;
  result_t              queue      [QUEUE_DEPTH];
  result_t              queue_next [QUEUE_DEPTH];
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [COUNT_W-1:0]   base;
  logic [1:0]           nres;
  logic                 push;
  logic                 pop;

  slu_decode u_decode (
    .state     (state),
    .in_byte   (in_byte),
    .frame_end (frame_end),
    .dec       (dec)
  );

  assign out_valid = (count != '0);
  assign in_stall  = (count > COUNT_W'(QUEUE_DEPTH - 2));
  assign push      = in_valid & ~in_stall;
  assign pop       = out_valid & ~out_stall;
  assign nres      = push ? dec.num : 2'd0;
  assign base      = count - COUNT_W'(pop);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_next[i] = queue[i];
    end
    if (pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        queue_next[i] = queue[i + 1];
      end
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (COUNT_W'(i) == base && nres != 2'd0) begin
        queue_next[i] = dec.r0;
      end
      if (COUNT_W'(i) == base + COUNT_W'(1) && nres == 2'd2) begin
        queue_next[i] = dec.r1;
      end
    end
    count_next = base + COUNT_W'(nres);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      state <= STATE_RESET;
    end else begin
      count <= count_next;
      if (push) begin
        state <= dec.state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
  end

  assign out_byte    = queue[0].out_byte;
  assign is_data     = queue[0].is_data;
  assign well_formed = queue[0].well_formed;
  assign run_last    = queue[0].run_last;

endmodule

@@ rtl/core/slu_checker.sv @@
// port-level checks for the string literal unescape block, with bind
module slu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       well_formed,
  input logic       run_last
);

  // output request held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_data)
      && $stable(well_formed) && $stable(run_last))
    else $error("stalled output request changed");

  // status results carry no byte and close the request
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> out_byte == 8'd0 && run_last)
    else $error("malformed status result");

  // data results never claim well formed
  a_data_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_data |-> !well_formed)
    else $error("data result with well_formed set");

  // queue empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind string_literal_unescape_top slu_checker u_slu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .is_data     (is_data),
  .well_formed (well_formed),
  .run_last    (run_last)
);

@@ sim/tb_string_literal_unescape_top.sv @@
// self-checking testbench for string_literal_unescape_top with a built-in decode predictor
`timescale 1ns / 1ps

module tb_string_literal_unescape_top;
  import slu_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int DRAIN_CYCLES   = 4;

  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_Q       = 8'h71;
  localparam logic [7:0] CH_Z       = 8'h7a;
  localparam logic [7:0] CH_DIGIT_7 = 8'h37;
  localparam logic [7:0] CH_DIGIT_5 = 8'h35;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_data;
  logic       well_formed;
  logic       run_last;

  string_literal_unescape_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_data     (is_data),
    .well_formed (well_formed),
    .run_last    (run_last)
  );

  always #5 clk = ~clk;

  // decoder state mirror
  mode_t      dec_mode = MODE_OPEN;
  logic       digit_held = 1'b0;
  logic [3:0] held_nibble = 4'h0;
  logic       bad_open = 1'b0;

  result_t    step_out [2];
  int         step_n;
  result_t    decoded_q [$];
  result_t    want;

  int errors = 0;
  int requests_sent = 0;
  int data_results = 0;
  int status_results = 0;
  int clean_literals = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holdoffs_asked = 0;
  int holdoffs_begun = 0;
  int holdoff_left = 0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic void add_result(input logic [7:0] b, input logic d, input logic wf);
    step_out[step_n] = '{out_byte: b, is_data: d, well_formed: wf, run_last: 1'b0};
    step_n++;
  endfunction

  function automatic void clear_decoder();
    dec_mode    = MODE_OPEN;
    digit_held  = 1'b0;
    held_nibble = 4'h0;
    bad_open    = 1'b0;
  endfunction

  function automatic void decode_plain(input logic [7:0] b);
    if (b == CH_BACKSLASH) dec_mode = MODE_ESC;
    else add_result(b, 1'b1, 1'b0);
  endfunction

  task automatic predict_unescape(input logic [7:0] b, input logic fe);
    int d;
    logic [7:0] v;
    step_n = 0;
    if (dec_mode == MODE_OPEN) begin
      if (fe) begin
        add_result(8'h00, 1'b0, 1'b0);
        clear_decoder();
      end else begin
        bad_open = (b != CH_QUOTE);
        dec_mode = MODE_BODY;
      end
    end else if (fe) begin
      if (dec_mode == MODE_ESC) add_result(CH_BACKSLASH, 1'b1, 1'b0);
      else if (dec_mode == MODE_HEX && digit_held) add_result({4'h0, held_nibble}, 1'b1, 1'b0);
      add_result(8'h00, 1'b0, !bad_open && b == CH_QUOTE);
      clear_decoder();
    end else begin
      case (dec_mode)
        MODE_BODY: begin
          decode_plain(b);
        end
        MODE_ESC: begin
          if (b == CH_X) begin
            dec_mode    = MODE_HEX;
            digit_held  = 1'b0;
            held_nibble = 4'h0;
          end else begin
            case (b)
              CH_N:    v = BYTE_LF;
              CH_R:    v = BYTE_CR;
              CH_T:    v = BYTE_TAB;
              CH_ZERO: v = BYTE_NUL;
              default: v = b;
            endcase
            add_result(v, 1'b1, 1'b0);
            dec_mode = MODE_BODY;
          end
        end
        default: begin
          d = hex_nibble(b);
          if (d >= 0) begin
            if (!digit_held) begin
              held_nibble = 4'(d);
              digit_held  = 1'b1;
            end else begin
              add_result({held_nibble, 4'(d)}, 1'b1, 1'b0);
              digit_held  = 1'b0;
              held_nibble = 4'h0;
              dec_mode    = MODE_BODY;
            end
          end else begin
            if (digit_held) add_result({4'h0, held_nibble}, 1'b1, 1'b0);
            digit_held  = 1'b0;
            held_nibble = 4'h0;
            dec_mode    = MODE_BODY;
            decode_plain(b);
          end
        end
      endcase
    end
    if (step_n > 0) step_out[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q = {decoded_q, step_out[i]};
  endtask

  task automatic send_request(input logic [7:0] b, input logic fe);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_unescape(b, fe);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
  endfunction

  task automatic send_random_token();
    logic [7:0] esc_chars [7];
    int digits;
    esc_chars = '{CH_N, CH_R, CH_T, CH_ZERO, CH_BACKSLASH, CH_QUOTE, CH_Q};
    case ($urandom_range(9))
      5, 6: begin
        send_request(CH_BACKSLASH, 1'b0);
        if ($urandom_range(3) == 0) send_request(8'($urandom), 1'b0);
        else send_request(esc_chars[$urandom_range(6)], 1'b0);
      end
      7, 8: begin
        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_X, 1'b0);
        digits = $urandom_range(2);
        for (int i = 0; i < digits; i++) send_request(rand_hex_char(), 1'b0);
      end
      9: send_request(CH_BACKSLASH, 1'b0);
      default: send_request(8'($urandom), 1'b0);
    endcase
  endtask

  task automatic send_random_frame();
    int body_len;
    if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b0);
    else send_request(CH_QUOTE, 1'b0);
    body_len = $urandom_range(10);
    for (int i = 0; i < body_len; i++) send_random_token();
    if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b1);
    else send_request(CH_QUOTE, 1'b1);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) send_request(8'($urandom), $urandom_range(3) == 0);
  endtask

  // all named escapes, unknown escape, two-digit hex, one digit then non-digit
  task automatic test_escapes();
    logic [7:0] esc_chars [7];
    esc_chars = '{CH_N, CH_R, CH_T, CH_ZERO, CH_BACKSLASH, CH_QUOTE, CH_Q};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(CH_QUOTE, 1'b0);
    foreach (esc_chars[i]) begin
      send_request(CH_BACKSLASH, 1'b0);
      send_request(esc_chars[i], 1'b0);
    end
    send_request(CH_BACKSLASH, 1'b0);
    send_request(CH_X, 1'b0);
    send_request(CH_UPPER_A, 1'b0);
    send_request(CH_DIGIT_5, 1'b0);
    send_request(CH_BACKSLASH, 1'b0);
    send_request(CH_X, 1'b0);
    send_request(CH_DIGIT_7, 1'b0);
    send_request(CH_Z, 1'b0);
    send_request(CH_QUOTE, 1'b1);
    wait_drained();
  endtask

  // one-byte frame, bad open, hex escape cut by close, backslash before bad close
  task automatic test_special_cases();
    send_request(8'hff, 1'b1);
    send_request(8'h00, 1'b0);
    send_request(CH_BACKSLASH, 1'b0);
    send_request(CH_X, 1'b0);
    send_request(CH_QUOTE, 1'b1);
    send_request(CH_QUOTE, 1'b0);
    send_request(CH_BACKSLASH, 1'b0);
    send_request(8'hff, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    int start;
    start              = requests_sent;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (requests_sent - start < count) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_random_frame();
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_output_holdoff();
    int start;
    start              = requests_sent;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    holdoffs_asked++;
    while (requests_sent - start < 40) send_random_frame();
    wait_drained();
  endtask

  // sender stops mid-literal until every pending result is out
  task automatic test_midframe_pause();
    int tokens;
    sender_idle_pct    = 13;
    receiver_stall_pct = 13;
    repeat (6) begin
      send_request(CH_QUOTE, 1'b0);
      tokens = $urandom_range(1, 4);
      for (int i = 0; i < tokens; i++) send_random_token();
      wait_drained();
      send_random_token();
      send_request(CH_QUOTE, 1'b1);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_begun != holdoffs_asked) begin
      out_stall      <= 1'b1;
      holdoff_left   <= HOLDOFF_CYCLES;
      holdoffs_begun <= holdoffs_begun + 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: out_byte %h is_data %b well_formed %b run_last %b",
                 $time, out_byte, is_data, well_formed, run_last);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("is_data", 8'(want.is_data), 8'(is_data));
        check_field("well_formed", 8'(want.well_formed), 8'(well_formed));
        check_field("run_last", 8'(want.run_last), 8'(run_last));
      end
      if (is_data) data_results++;
      else begin
        status_results++;
        if (well_formed) clean_literals++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles, %0d results pending",
               $time, WATCHDOG_LIMIT, decoded_q.size());
      $display("string_literal_unescape_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_escapes();
    test_special_cases();
    test_random_traffic(255, 0, 0);
    test_random_traffic(255, 81, 0);
    test_random_traffic(255, 0, 81);
    test_random_traffic(255, 13, 13);
    test_output_holdoff();
    test_midframe_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      errors++;
    end
    $display("covered %0d requests: %0d decoded bytes, %0d literal status results (%0d clean)",
             requests_sent, data_results, status_results, clean_literals);
    $display("traffic ran with no idling, sender gaps, receiver stalls, both, and a long holdoff");
    if (errors == 0) begin
      $display("string_literal_unescape_top verification clean");
    end else begin
      $display("string_literal_unescape_top verification failed");
    end
    $finish;
  end

endmodule
